FILE: rtl/core/single_wire_humidity_sensor_reader_defines.svh
// assertion macros for the single-wire humidity sensor reader
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_DEFINES_SVH

`ifndef SYNTH
// property must hold on every clock edge out of reset
`define SWH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define SWH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define SWH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWH_ASSERT(label, clk, rst_n, prop, msg)
`define SWH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SWH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/core/swh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swh_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_START_LOW_TICKS      = 3'd0,
		REG_RESPONSE_FIRST_WAIT  = 3'd1,
		REG_RESPONSE_SECOND_WAIT = 3'd2,
		REG_BIT_SAMPLE_TICKS     = 3'd3,
		REG_FRAME_BYTES          = 3'd4
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// response status codes
	typedef enum logic [1:0] {
		RESP_NONE = 2'd0,
		RESP_OK   = 2'd1,
		RESP_BAD  = 2'd2
	} resp_status_t;

	// register reset values
	localparam logic [15:0] START_LOW_TICKS_RST      = 16'd18000;
	localparam logic [15:0] RESPONSE_FIRST_WAIT_RST  = 16'd40;
	localparam logic [15:0] RESPONSE_SECOND_WAIT_RST = 16'd80;
	localparam logic [15:0] BIT_SAMPLE_TICKS_RST     = 16'd40;
	localparam logic [3:0]  FRAME_BYTES_RST          = 4'd5;

endpackage

`default_nettype wire

FILE: rtl/core/swh_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input item channel: one tick with pin sample, or a start request
interface swh_in_if;
	logic valid;
	logic ready;
	logic action;
	logic pin_level;

	modport source (output valid, output action, output pin_level, input ready);
	modport sink (input valid, input action, input pin_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/swh_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// result channel
interface swh_out_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       response_valid;
	logic [1:0] response_status;
	logic       byte_valid;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (
		output valid, output drive_low, output response_valid, output response_status,
		output byte_valid, output byte_value, output last_byte, input ready
	);
	modport sink (
		input valid, input drive_low, input response_valid, input response_status,
		input byte_valid, input byte_value, input last_byte, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/swh_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

// configuration write channel
interface swh_cfg_if;
	import swh_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/single_wire_humidity_sensor_reader.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  payload
// item      in         action, pin_level
// result    out        drive_low, response_valid, response_status,
//                      byte_valid, byte_value, last_byte
// cfg       in         index (3 bits), data (16 bits), always ready
//
// one item per cycle unless the result stalls; each item passes an input
// register, then the protocol state machine computes its result into
// the output register, which presents it on the result channel.
// arst_n clears the state machine, counters and valid flags and loads
// the register defaults. a stalled result holds both stages; the input
// register still takes an item while the output waits if it is empty.

`include "single_wire_humidity_sensor_reader_defines.svh"

module single_wire_humidity_sensor_reader (
	input  wire logic  clk,
	input  wire logic  arst_n,
	swh_in_if.sink     item,
	swh_out_if.source  result,
	swh_cfg_if.sink    cfg
);
	import swh_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_START_LOW   = 3'd1,
		PH_WAIT_FIRST  = 3'd2,
		PH_WAIT_SECOND = 3'd3,
		PH_WAIT_FALL   = 3'd4,
		PH_BIT_HIGH    = 3'd5,
		PH_BIT_DELAY   = 3'd6,
		PH_BIT_LOW     = 3'd7
	} phase_t;

	// configuration registers
	logic [15:0] start_low_ticks_q;
	logic [15:0] response_first_wait_q;
	logic [15:0] response_second_wait_q;
	logic [15:0] bit_sample_ticks_q;
	logic [3:0]  frame_bytes_q;

	// input stage
	logic valid_s1;
	logic action_s1;
	logic pin_s1;

	// protocol state
	phase_t       phase_q, phase_d;
	logic [15:0]  tick_q, tick_d, tick_inc;
	logic [7:0]   shift_q, shift_d;
	logic [2:0]   bit_q, bit_d;
	logic [3:0]   bytes_q, bytes_d;
	resp_status_t pend_q, pend_d;

	// result computed from the input stage
	logic         resp_valid_d;
	resp_status_t resp_status_d;
	logic         byte_valid_d;
	logic [7:0]   byte_value_d;
	logic         last_byte_d;
	logic         fin_bit, rep_resp;

	// output register
	logic         out_valid_q;
	logic         drive_low_q;
	logic         resp_valid_q;
	resp_status_t resp_status_q;
	logic         byte_valid_q;
	logic [7:0]   byte_value_q;
	logic         last_byte_q;

	logic advance;

	// stage moves when the output register is free or being drained
	assign advance    = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_ticks_q      <= START_LOW_TICKS_RST;
			response_first_wait_q  <= RESPONSE_FIRST_WAIT_RST;
			response_second_wait_q <= RESPONSE_SECOND_WAIT_RST;
			bit_sample_ticks_q     <= BIT_SAMPLE_TICKS_RST;
			frame_bytes_q          <= FRAME_BYTES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_LOW_TICKS:      start_low_ticks_q      <= cfg.data;
				REG_RESPONSE_FIRST_WAIT:  response_first_wait_q  <= cfg.data;
				REG_RESPONSE_SECOND_WAIT: response_second_wait_q <= cfg.data;
				REG_BIT_SAMPLE_TICKS:     bit_sample_ticks_q     <= cfg.data;
				REG_FRAME_BYTES:          frame_bytes_q          <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			pin_s1    <= item.pin_level;
		end
	end

	assign tick_inc = tick_q + 16'd1;

	// next state and result for the item in the input stage
	always_comb begin
		phase_d       = phase_q;
		tick_d        = tick_q;
		shift_d       = shift_q;
		bit_d         = bit_q;
		bytes_d       = bytes_q;
		pend_d        = pend_q;
		resp_valid_d  = 1'b0;
		resp_status_d = RESP_NONE;
		byte_valid_d  = 1'b0;
		byte_value_d  = 8'd0;
		last_byte_d   = 1'b0;
		fin_bit       = 1'b0;
		rep_resp      = 1'b0;

		if (action_s1) begin
			phase_d = PH_START_LOW;
			tick_d  = 16'd0;
			shift_d = 8'd0;
			bit_d   = 3'd0;
			bytes_d = 4'd0;
			pend_d  = RESP_NONE;
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_START_LOW: begin
					tick_d = tick_inc;
					if (tick_inc >= start_low_ticks_q) begin
						phase_d = PH_WAIT_FIRST;
						tick_d  = 16'd0;
					end
				end
				PH_WAIT_FIRST: begin
					tick_d = tick_inc;
					if (tick_inc >= response_first_wait_q) begin
						tick_d = 16'd0;
						if (!pin_s1) begin
							phase_d = PH_WAIT_SECOND;
						end else begin
							pend_d  = RESP_NONE;
							phase_d = PH_WAIT_FALL;
						end
					end
				end
				PH_WAIT_SECOND: begin
					tick_d = tick_inc;
					if (tick_inc >= response_second_wait_q) begin
						tick_d = 16'd0;
						if (pin_s1) begin
							pend_d  = RESP_OK;
							phase_d = PH_WAIT_FALL;
						end else begin
							pend_d   = RESP_BAD;
							rep_resp = 1'b1;
						end
					end
				end
				PH_WAIT_FALL: begin
					rep_resp = !pin_s1;
				end
				PH_BIT_HIGH: begin
					if (pin_s1) begin
						phase_d = PH_BIT_DELAY;
						tick_d  = 16'd0;
					end
				end
				PH_BIT_DELAY: begin
					tick_d = tick_inc;
					if (tick_inc >= bit_sample_ticks_q) begin
						tick_d = 16'd0;
						if (pin_s1) begin
							shift_d[~bit_q] = 1'b1;
							phase_d         = PH_BIT_LOW;
						end else begin
							fin_bit = 1'b1;
						end
					end
				end
				PH_BIT_LOW: begin
					fin_bit = !pin_s1;
				end
			endcase

			// response report once the wire is low
			if (rep_resp) begin
				resp_valid_d  = 1'b1;
				resp_status_d = pend_d;
				if (pend_d == RESP_OK) begin
					phase_d = PH_BIT_HIGH;
					bit_d   = 3'd0;
					bytes_d = 4'd0;
					shift_d = 8'd0;
				end else begin
					phase_d = PH_IDLE;
				end
			end

			// end of bit, byte delivered after the eighth
			if (fin_bit) begin
				if (bit_q == 3'd7) begin
					byte_valid_d = 1'b1;
					byte_value_d = shift_d;
					bytes_d      = bytes_q + 4'd1;
					if (bytes_d >= frame_bytes_q) begin
						last_byte_d = 1'b1;
						phase_d     = PH_IDLE;
					end else begin
						phase_d = PH_BIT_HIGH;
					end
					bit_d   = 3'd0;
					shift_d = 8'd0;
				end else begin
					bit_d   = bit_q + 3'd1;
					phase_d = PH_BIT_HIGH;
				end
			end
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= 16'd0;
			shift_q     <= 8'd0;
			bit_q       <= 3'd0;
			bytes_q     <= 4'd0;
			pend_q      <= RESP_NONE;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_d;
				tick_q  <= tick_d;
				shift_q <= shift_d;
				bit_q   <= bit_d;
				bytes_q <= bytes_d;
				pend_q  <= pend_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			drive_low_q   <= (phase_d == PH_START_LOW);
			resp_valid_q  <= resp_valid_d;
			resp_status_q <= resp_status_d;
			byte_valid_q  <= byte_valid_d;
			byte_value_q  <= byte_value_d;
			last_byte_q   <= last_byte_d;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.drive_low       = drive_low_q;
	assign result.response_valid  = resp_valid_q;
	assign result.response_status = resp_status_q;
	assign result.byte_valid      = byte_valid_q;
	assign result.byte_value      = byte_value_q;
	assign result.last_byte       = last_byte_q;

	// checks
	`SWH_ASSERT_NEXT(a_stage_to_out, clk, arst_n, advance && valid_s1, out_valid_q, "item in input stage lost")
	`SWH_ASSERT_IMPL(a_drive_phase, clk, arst_n, out_valid_q && drive_low_q, phase_q == PH_START_LOW, "drive_low without start phase")
	`SWH_ASSERT_IMPL(a_one_event, clk, arst_n, out_valid_q, !(resp_valid_q && byte_valid_q), "response and byte in one result")
	`SWH_ASSERT_IMPL(a_last_has_byte, clk, arst_n, out_valid_q && last_byte_q, byte_valid_q, "last_byte without a byte")
	`SWH_ASSERT_IMPL(a_bad_ends, clk, arst_n, out_valid_q && resp_valid_q && resp_status_q != RESP_OK, phase_q == PH_IDLE, "failed response left block busy")

endmodule

`default_nettype wire
